// ===== design/url_percent_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// url_percent_encoder_core_macros.svh
// Assertion macros used by the checker file of the percent encoder
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_ENCODER_CORE_MACROS_SVH
`define URL_PERCENT_ENCODER_CORE_MACROS_SVH

// concurrent check on clk, off while reset is asserted
`define UPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// concurrent check on clk that also holds during reset
`define UPE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/upe_pkg.sv =====
// ----------------------------------------------------------------------------
// upe_pkg
// Types, constants and byte classification functions of the percent encoder
// ----------------------------------------------------------------------------
package upe_pkg;

	// configuration register indexes
	localparam logic REG_ENCODE_SET    = 1'b0;
	localparam logic REG_SPACE_AS_PLUS = 1'b1;

	// widths fixed by the item format
	localparam int unsigned CP_W   = 21;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_W  = 3;

	// default depth of the descriptor queue
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// characters with a special role
	localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CHR_PLUS    = 8'h2B;
	localparam logic [BYTE_W-1:0] CHR_PERCENT = 8'h25;

	// percent-encode set selection
	typedef enum logic [CFG_W-1:0] {
		SET_C0        = 3'd0,
		SET_FRAGMENT  = 3'd1,
		SET_QUERY     = 3'd2,
		SET_SPECIAL_Q = 3'd3,
		SET_PATH      = 3'd4,
		SET_USERINFO  = 3'd5,
		SET_COMPONENT = 3'd6
	} encode_set_t;

	// how one utf-8 byte is emitted
	typedef enum logic [1:0] {
		MODE_PASS   = 2'd0,
		MODE_PLUS   = 2'd1,
		MODE_ESCAPE = 2'd2
	} byte_mode_t;

	// one classified code point, as queued between front and back
	typedef struct packed {
		logic [3:0][BYTE_W-1:0] bytes;
		byte_mode_t [3:0]       mode;
		logic [1:0]             last_idx;
	} item_desc_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic in_c0(input logic [BYTE_W-1:0] b);
		return (b <= 8'h1F) || (b > 8'h7E);
	endfunction

	function automatic logic in_query(input logic [BYTE_W-1:0] b);
		return in_c0(b) || b == 8'h20 || b == 8'h22 || b == 8'h23 ||
			b == 8'h3C || b == 8'h3E;
	endfunction

	function automatic logic in_path(input logic [BYTE_W-1:0] b);
		return in_query(b) || b == 8'h3F || b == 8'h60 || b == 8'h7B ||
			b == 8'h7D;
	endfunction

	function automatic logic in_userinfo(input logic [BYTE_W-1:0] b);
		return in_path(b) || b == 8'h2F || b == 8'h3A || b == 8'h3B ||
			b == 8'h3D || b == 8'h40 || (b >= 8'h5B && b <= 8'h5E) ||
			b == 8'h7C;
	endfunction

	// membership of byte b in the selected set; the unused code is empty
	function automatic logic in_set(input encode_set_t set, input logic [BYTE_W-1:0] b);
		logic r;
		unique case (set)
			SET_C0:        r = in_c0(b);
			SET_FRAGMENT:  r = in_c0(b) || b == 8'h20 || b == 8'h22 || b == 8'h3C ||
				b == 8'h3E || b == 8'h60;
			SET_QUERY:     r = in_query(b);
			SET_SPECIAL_Q: r = in_query(b) || b == 8'h27;
			SET_PATH:      r = in_path(b);
			SET_USERINFO:  r = in_userinfo(b);
			SET_COMPONENT: r = in_userinfo(b) || (b >= 8'h24 && b <= 8'h26) ||
				b == 8'h2B || b == 8'h2C;
			default:       r = 1'b0;
		endcase
		return r;
	endfunction

	// upper-case hex digit
	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

endpackage

// ===== design/upe_front.sv =====
// ----------------------------------------------------------------------------
// upe_front
// Accepts code points, encodes them to utf-8 and classifies every byte
// ----------------------------------------------------------------------------
module upe_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [upe_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [upe_pkg::CP_W-1:0]    code_point,
	input  upe_pkg::queue_stat_t        q_stat,
	output logic                        push,
	output upe_pkg::item_desc_t         desc
);
	import upe_pkg::*;

	encode_set_t encode_set_q;
	logic        space_as_plus_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_set_q    <= SET_C0;
			space_as_plus_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENCODE_SET:    encode_set_q    <= encode_set_t'(cfg_wdata);
				REG_SPACE_AS_PLUS: space_as_plus_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	// accept whenever the queue has room
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	// utf-8 encode and per-byte classification
	always_comb begin
		desc.bytes = '0;
		if (code_point[20:7] == '0) begin
			desc.bytes[0]  = {1'b0, code_point[6:0]};
			desc.last_idx  = 2'd0;
		end else if (code_point[20:11] == '0) begin
			desc.bytes[0]  = {3'b110, code_point[10:6]};
			desc.bytes[1]  = {2'b10, code_point[5:0]};
			desc.last_idx  = 2'd1;
		end else if (code_point[20:16] == '0) begin
			desc.bytes[0]  = {4'b1110, code_point[15:12]};
			desc.bytes[1]  = {2'b10, code_point[11:6]};
			desc.bytes[2]  = {2'b10, code_point[5:0]};
			desc.last_idx  = 2'd2;
		end else begin
			desc.bytes[0]  = {5'b11110, code_point[20:18]};
			desc.bytes[1]  = {2'b10, code_point[17:12]};
			desc.bytes[2]  = {2'b10, code_point[11:6]};
			desc.bytes[3]  = {2'b10, code_point[5:0]};
			desc.last_idx  = 2'd3;
		end
		for (int i = 0; i < 4; i++) begin
			if (space_as_plus_q && desc.bytes[i] == CHR_SPACE)
				desc.mode[i] = MODE_PLUS;
			else if (in_set(encode_set_q, desc.bytes[i]))
				desc.mode[i] = MODE_ESCAPE;
			else
				desc.mode[i] = MODE_PASS;
		end
	end

endmodule

// ===== design/upe_queue.sv =====
// ----------------------------------------------------------------------------
// upe_queue
// Short queue of classified code points between front and back
// ----------------------------------------------------------------------------
module upe_queue #(
	parameter int unsigned DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  upe_pkg::item_desc_t   wdata,
	input  logic                  pop,
	output upe_pkg::item_desc_t   rdata,
	output upe_pkg::queue_stat_t  stat
);
	import upe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_desc_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/upe_back.sv =====
// ----------------------------------------------------------------------------
// upe_back
// Serializes queued code points into bytes, one beat per cycle unless stalled
// ----------------------------------------------------------------------------
module upe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  upe_pkg::item_desc_t          head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [upe_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last_of_item
);
	import upe_pkg::*;

	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_HI   = 2'd1,
		PH_LO   = 2'd2
	} phase_t;

	phase_t              phase_q;
	logic [1:0]          idx_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_q;

	logic                load;
	logic                fire;
	logic [BYTE_W-1:0]   cur_byte;
	byte_mode_t          cur_mode;
	logic [BYTE_W-1:0]   chr;
	logic                byte_done;
	logic                item_done;
	phase_t              phase_nxt;

	// output register frees up when empty or taken
	assign load     = !out_valid_q || out_ready;
	assign fire     = load && head_valid;
	assign cur_byte = head.bytes[idx_q];
	assign cur_mode = head.mode[idx_q];

	// next character of the current byte
	always_comb begin
		chr       = cur_byte;
		byte_done = 1'b1;
		phase_nxt = PH_LEAD;
		if (cur_mode == MODE_ESCAPE) begin
			unique case (phase_q)
				PH_LEAD: begin
					chr       = CHR_PERCENT;
					byte_done = 1'b0;
					phase_nxt = PH_HI;
				end
				PH_HI: begin
					chr       = hex_char(cur_byte[7:4]);
					byte_done = 1'b0;
					phase_nxt = PH_LO;
				end
				PH_LO: begin
					chr       = hex_char(cur_byte[3:0]);
					byte_done = 1'b1;
					phase_nxt = PH_LEAD;
				end
				default: begin
					chr       = cur_byte;
					byte_done = 1'b1;
					phase_nxt = PH_LEAD;
				end
			endcase
		end else if (cur_mode == MODE_PLUS) begin
			chr = CHR_PLUS;
		end
	end

	assign item_done = byte_done && (idx_q == head.last_idx);
	assign pop       = fire && item_done;

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= head_valid;
			if (fire) begin
				out_byte_q <= chr;
				last_q     <= item_done;
				phase_q    <= phase_nxt;
				if (byte_done)
					idx_q <= item_done ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = last_q;

endmodule

// ===== design/url_percent_encoder_core.sv =====
// ----------------------------------------------------------------------------
// url_percent_encoder_core
// Utf-8 encoder and url percent encoder, one code point in, 1 to 12 bytes out
// ----------------------------------------------------------------------------
// Each input beat carries one code point; it leaves as 1 to 12 output beats,
// emitted by the back-end serializer one byte per cycle while out_ready takes
// them, the last one flagged by last_of_item. Plain ascii gives one byte, a
// four byte sequence with every byte escaped gives 12. The front end takes a
// new code point every cycle while the descriptor queue (QUEUE_DEPTH entries)
// has room, so input and output stall independently. An accepted code point
// passes through the descriptor queue and the back-end output register before
// its first output beat is presented. Configuration is written through
// cfg_we/cfg_index/cfg_wdata while the block is idle, a rule for the user that
// the block itself does not enforce; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module url_percent_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [upe_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [upe_pkg::CP_W-1:0]    code_point,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [upe_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last_of_item
);
	import upe_pkg::*;

	queue_stat_t q_stat;
	item_desc_t  wr_desc;
	item_desc_t  head_desc;
	logic        push;
	logic        pop;

	// encode and classify
	upe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_point (code_point),
		.q_stat     (q_stat),
		.push       (push),
		.desc       (wr_desc)
	);

	// descriptor queue
	upe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_desc),
		.pop    (pop),
		.rdata  (head_desc),
		.stat   (q_stat)
	);

	// byte serializer
	upe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_stat.empty),
		.head         (head_desc),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

endmodule

// ===== design/upe_checker.sv =====
// ----------------------------------------------------------------------------
// upe_checker
// Port-level checks of the percent encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "url_percent_encoder_core_macros.svh"

module upe_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [upe_pkg::BYTE_W-1:0]  out_byte,
	input  logic                        last_of_item
);
	logic [3:0] beats_q;
	logic [7:0] pend_q;
	logic       in_acc;
	logic       out_acc;
	logic       item_end;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign item_end = out_acc && last_of_item;

	// beats of the current item and items accepted but not finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_q <= '0;
			pend_q  <= '0;
		end else begin
			if (item_end)
				beats_q <= '0;
			else if (out_acc)
				beats_q <= beats_q + 4'd1;
			if (in_acc && !item_end)
				pend_q <= pend_q + 8'd1;
			else if (item_end && !in_acc)
				pend_q <= pend_q - 8'd1;
		end
	end

	// output register is cleared asynchronously as soon as reset is asserted
	`UPE_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "output valid during reset")
	`UPE_ASSERT(a_out_hold,
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_item),
		"stalled output beat changed")
	`UPE_ASSERT(a_max_beats, out_valid |-> beats_q < 4'd12,
		"more than twelve bytes for one code point")
	`UPE_ASSERT(a_no_orphan, out_valid |-> pend_q != 8'd0,
		"output beat without an accepted code point")

endmodule

bind url_percent_encoder_core upe_checker u_upe_checker (.*);

// ===== tb/url_percent_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// url_percent_encoder_core_tb
// Self-checking bench for the utf-8 / url percent encoder
// ----------------------------------------------------------------------------
// Code points go in through a valid/ready driver fed from a queue. A local
// predictor works out the utf-8 bytes and their escaped form under the
// current encode set and space-as-plus setting. Every output beat is checked
// against the oldest predicted byte. The run starts with a short list of
// boundary code points on the reset settings. Then it steps through every
// encode set, the unused set code and both plus settings with random code
// points. One phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module url_percent_encoder_core_tb;
	import upe_pkg::*;

	// encode set code with no set behind it
	localparam logic [CFG_W-1:0] SET_UNUSED = 3'd7;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned RAND_PER_PHASE = 10;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              last;
	} enc_char_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CP_W-1:0]   code_point = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_item;

	// code points waiting for the driver, encoded bytes waiting for the dut
	logic [CP_W-1:0] pending_cps[$];
	enc_char_t       expected_chars[$];
	enc_char_t       want;

	// settings as the dut should hold them
	logic [CFG_W-1:0] cur_set = SET_C0;
	logic             cur_plus = 1'b0;

	bit          in_fire = 1'b0;
	bit          send_idle_on = 1'b1;
	bit          recv_idle_on = 1'b1;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned fail_count = 0;
	int unsigned n_cps = 0;
	int unsigned n_chars = 0;
	int unsigned n_escapes = 0;
	int unsigned n_settings = 0;

	url_percent_encoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_point   (code_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// membership of one utf-8 byte in the selected escape set
	function automatic bit needs_escape(input logic [CFG_W-1:0] sel,
			input logic [BYTE_W-1:0] b);
		bit ctl, qry, pth, usr;
		ctl = b < 8'h20 || b > 8'h7E;
		qry = ctl || b == 8'h20 || b == 8'h22 || b == 8'h23 || b == 8'h3C ||
			b == 8'h3E;
		pth = qry || b == 8'h3F || b == 8'h60 || b == 8'h7B || b == 8'h7D;
		usr = pth || b == 8'h2F || b == 8'h3A || b == 8'h3B || b == 8'h3D ||
			b == 8'h40 || (b >= 8'h5B && b <= 8'h5E) || b == 8'h7C;
		case (sel)
			SET_C0:        return ctl;
			SET_FRAGMENT:  return ctl || b == 8'h20 || b == 8'h22 || b == 8'h3C ||
				b == 8'h3E || b == 8'h60;
			SET_QUERY:     return qry;
			SET_SPECIAL_Q: return qry || b == 8'h27;
			SET_PATH:      return pth;
			SET_USERINFO:  return usr;
			SET_COMPONENT: return usr || (b >= 8'h24 && b <= 8'h26) || b == 8'h2B ||
				b == 8'h2C;
			default:       return 1'b0;
		endcase
	endfunction

	// upper-case ascii hex digit
	function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 | {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

	// utf-8 encode one code point, escape each byte, queue the result bytes
	task automatic predict_code_point(input logic [CP_W-1:0] cp);
		logic [BYTE_W-1:0] u [4];
		logic [BYTE_W-1:0] seq [12];
		int nb, n, i;
		enc_char_t e;
		if (cp < 21'h80) begin
			nb = 1;
			u[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			nb = 2;
			u[0] = {3'b110, cp[10:6]};
			u[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			nb = 3;
			u[0] = {4'b1110, cp[15:12]};
			u[1] = {2'b10, cp[11:6]};
			u[2] = {2'b10, cp[5:0]};
		end else begin
			nb = 4;
			u[0] = {5'b11110, cp[20:18]};
			u[1] = {2'b10, cp[17:12]};
			u[2] = {2'b10, cp[11:6]};
			u[3] = {2'b10, cp[5:0]};
		end
		n = 0;
		for (i = 0; i < nb; i++) begin
			if (cur_plus && u[i] == CHR_SPACE) begin
				seq[n] = CHR_PLUS;
				n++;
			end else if (needs_escape(cur_set, u[i])) begin
				seq[n]     = CHR_PERCENT;
				seq[n + 1] = nibble_char(u[i][7:4]);
				seq[n + 2] = nibble_char(u[i][3:0]);
				n += 3;
				n_escapes++;
			end else begin
				seq[n] = u[i];
				n++;
			end
		end
		for (i = 0; i < n; i++) begin
			e.ch   = seq[i];
			e.last = (i == n - 1);
			expected_chars.push_back(e);
		end
	endtask

	// random code point, weighted toward ascii where the sets differ
	function automatic logic [CP_W-1:0] rand_code_point();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return CP_W'($urandom_range(32'h7F, 32'h0));
		else if (r < 65)
			return CP_W'($urandom_range(32'h7FF, 32'h80));
		else if (r < 80)
			return CP_W'($urandom_range(32'hFFFF, 32'h800));
		else if (r < 95)
			return CP_W'($urandom_range(32'h10FFFF, 32'h10000));
		else
			return CP_W'($urandom_range(32'h1FFFFF, 32'h110000));
	endfunction

	// input driver: next code point once the current beat is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (pending_cps.size() != 0 &&
						!(send_idle_on && $urandom_range(99) < 20)) begin
					in_valid   <= 1'b1;
					code_point <= pending_cps.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output receiver: random stalls, or a long hold when asked
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(recv_idle_on && $urandom_range(99) < 20);
		end
	end

	// monitor: predict on input beats, check output beats
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && in_ready;
		if (in_fire) begin
			predict_code_point(code_point);
			n_cps++;
		end
		if (arst_n && out_valid && out_ready) begin
			n_chars++;
			if (expected_chars.size() == 0) begin
				$error("output beat with nothing expected: out_byte=%02h last_of_item=%b",
					out_byte, last_of_item);
				fail_count++;
			end else begin
				want = expected_chars.pop_front();
				if (out_byte !== want.ch) begin
					$error("out_byte: expected %02h, got %02h", want.ch, out_byte);
					fail_count++;
				end
				if (last_of_item !== want.last) begin
					$error("last_of_item: expected %b, got %b", want.last, last_of_item);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d bytes still expected",
				WATCHDOG_LIMIT, expected_chars.size());
			$display("Verification failed");
			$finish;
		end
	end

	// register write, mirrored into the predictor settings
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_ENCODE_SET)
			cur_set = val;
		else
			cur_plus = val[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every code point is sent and every byte has come back;
	// checked at the rising edge, where the driver outputs are settled
	task automatic wait_drained();
		while (pending_cps.size() != 0 || in_valid || expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// one setting: a space first, then random code points
	task automatic run_phase(input logic [CFG_W-1:0] sel, input logic plus,
			input bit squeeze);
		int k;
		wait_drained();
		write_reg(REG_ENCODE_SET, sel);
		write_reg(REG_SPACE_AS_PLUS, {{(CFG_W-1){1'b0}}, plus});
		@(posedge clk);
		send_idle_on = !squeeze;
		recv_idle_on = !squeeze;
		if (squeeze)
			hold_req = 1'b1;
		pending_cps.push_back(CP_W'(CHR_SPACE));
		for (k = 0; k < RAND_PER_PHASE; k++)
			pending_cps.push_back(rand_code_point());
		n_settings++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// boundaries of each utf-8 length, surrogates, beyond unicode, on reset settings
		n_settings++;
		pending_cps.push_back(21'h000000);
		pending_cps.push_back(21'h00001F);
		pending_cps.push_back(21'h000020);
		pending_cps.push_back(21'h000041);
		pending_cps.push_back(21'h00007E);
		pending_cps.push_back(21'h00007F);
		pending_cps.push_back(21'h000080);
		pending_cps.push_back(21'h0007FF);
		pending_cps.push_back(21'h000800);
		pending_cps.push_back(21'h00D800);
		pending_cps.push_back(21'h00DFFF);
		pending_cps.push_back(21'h00FFFF);
		pending_cps.push_back(21'h010000);
		pending_cps.push_back(21'h10FFFF);
		pending_cps.push_back(21'h110000);
		pending_cps.push_back(21'h1FFFFF);

		// sweep the sets; the path phase runs without idles and with a long hold
		run_phase(SET_C0,        1'b0, 1'b0);
		run_phase(SET_FRAGMENT,  1'b1, 1'b0);
		run_phase(SET_QUERY,     1'b0, 1'b0);
		run_phase(SET_SPECIAL_Q, 1'b1, 1'b0);
		run_phase(SET_PATH,      1'b0, 1'b1);
		run_phase(SET_USERINFO,  1'b1, 1'b0);
		run_phase(SET_COMPONENT, 1'b0, 1'b0);
		run_phase(SET_COMPONENT, 1'b1, 1'b0);
		run_phase(SET_UNUSED,    1'b1, 1'b0);
		run_phase(SET_UNUSED,    1'b0, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("encoded %0d code points into %0d output bytes (%0d escaped bytes)",
			n_cps, n_chars, n_escapes);
		$display("over %0d encoder settings, including the unused set code", n_settings);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/upe_pkg.sv
design/upe_front.sv
design/upe_queue.sv
design/upe_back.sv
design/url_percent_encoder_core.sv
design/upe_checker.sv
tb/url_percent_encoder_core_tb.sv
